/* rtl/ltqc_pkg.sv */
// Shared types, constants and helpers for the line tokenizer.
// Used by every module of the line_tokenizer_quotes_comments block.
`default_nettype none

package ltqc_pkg;

  // Line and token limits
  localparam int unsigned MaxTokenCount = 16;
  localparam int unsigned LineLength    = 1024;

  // Field widths
  localparam int unsigned CharW  = 8;
  localparam int unsigned NumW   = 5;
  localparam int unsigned StartW = 10;
  localparam int unsigned LenW   = 11;
  localparam int unsigned PosW   = 11;   // holds 0..LineLength

  // Character codes
  localparam logic [CharW-1:0] CharNul       = 8'h00;
  localparam logic [CharW-1:0] CharNewline   = 8'h0A;
  localparam logic [CharW-1:0] CharSpace     = 8'h20;
  localparam logic [CharW-1:0] CharQuote     = 8'h22;
  localparam logic [CharW-1:0] CharBackslash = 8'h5C;
  localparam logic [CharW-1:0] CharZ         = 8'h7A;

  // Result kinds
  localparam logic KindToken   = 1'b0;
  localparam logic KindLineEnd = 1'b1;

  // Register map (word index on the APB port)
  localparam int unsigned AddrW = 4;
  localparam logic [1:0] RegCommentFirst  = 2'd0;
  localparam logic [1:0] RegCommentSecond = 2'd1;
  localparam logic [1:0] RegPrefixLength  = 2'd2;

  localparam logic [CharW-1:0] ResetCommentChar = 8'd59;
  localparam logic [1:0]       ResetPrefixLength = 2'd1;

  // Result queue
  localparam int unsigned ResQDepth = 4;
  localparam int unsigned ResQPtrW  = $clog2(ResQDepth);
  localparam int unsigned ResQCntW  = $clog2(ResQDepth + 1);

  typedef struct packed {
    logic [CharW-1:0] first;
    logic [CharW-1:0] second;
    logic [1:0]       plen;
  } cfg_t;

  typedef struct packed {
    logic [CharW-1:0]  prev;
    logic [PosW-1:0]   pos;
    logic [StartW-1:0] start;
    logic [NumW-1:0]   tokens;
    logic              quote;
    logic              esc;
    logic              skip;
    logic              limit;
    logic              cmnt;
  } st_t;

  typedef struct packed {
    logic              kind;
    logic [NumW-1:0]   num;
    logic [StartW-1:0] start;
    logic [LenW-1:0]   len;
    logic              last;
  } res_t;

  // Token start saturates one below the line length
  function automatic logic [StartW-1:0] sat_start(input logic [PosW-1:0] p);
    if (p > PosW'(LineLength - 1)) begin
      return StartW'(LineLength - 1);
    end else begin
      return p[StartW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/line_tokenizer_quotes_comments.sv */
// Top level of the streaming line tokenizer: input register, line state,
// APB registers and result queue. Depends on ltqc_pkg, ltqc_step, ltqc_resq.
//
// Usage:
//   Characters of a line arrive on the input channel (in_valid_i/in_ready_o,
//   character_i), one per transfer. Each token is reported on the output
//   channel as kind 0 with its index, start position and raw length; a NUL
//   or newline closes the line with a kind 1 result carrying the token count.
//   last_of_run_o marks the final result caused by one character.
//   A character accepted into the input register is processed from there by
//   the step logic, and its results are written into the result queue, whose
//   head is the registered output. Throughput is one character per clock
//   while the four-entry result queue has room for two results; the step
//   logic runs only then, so characters that give two results can hold the
//   input once the queue has filled.
//   When the receiver stalls, results collect in the queue and then the
//   input register holds its character and in_ready_o drops.
//   Reset clears the line state, the queue and the registers to their
//   defaults (';' prefix, length one). The user must write the registers
//   over APB only while the block is idle; the block does not enforce this.
`default_nettype none

module line_tokenizer_quotes_comments (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ltqc_pkg::CharW-1:0]      character_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            kind_o,
  output logic [ltqc_pkg::NumW-1:0]       token_number_o,
  output logic [ltqc_pkg::StartW-1:0]     token_start_o,
  output logic [ltqc_pkg::LenW-1:0]       token_length_o,
  output logic                            last_of_run_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ltqc_pkg::AddrW-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  ltqc_pkg::cfg_t                    cfg_q;
  ltqc_pkg::st_t                     st_q, st_d;
  logic                              in_valid_q;
  logic [ltqc_pkg::CharW-1:0]        char_q;
  logic [ltqc_pkg::CharW-1:0]        head0_q, head1_q;
  logic                              head0_we, head1_we;
  ltqc_pkg::res_t                    res0, res1, head;
  logic [1:0]                        res_cnt;
  logic [1:0]                        push_cnt;
  logic [ltqc_pkg::ResQCntW-1:0]     q_cnt;
  logic                              step_fire;
  logic                              pop;
  logic                              cfg_wr;
  logic [1:0]                        reg_idx;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first  <= ltqc_pkg::ResetCommentChar;
      cfg_q.second <= ltqc_pkg::ResetCommentChar;
      cfg_q.plen   <= ltqc_pkg::ResetPrefixLength;
    end else if (cfg_wr) begin
      case (reg_idx)
        ltqc_pkg::RegCommentFirst:  cfg_q.first  <= pwdata[7:0];
        ltqc_pkg::RegCommentSecond: cfg_q.second <= pwdata[7:0];
        ltqc_pkg::RegPrefixLength:  cfg_q.plen   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ltqc_pkg::RegCommentFirst:  prdata = {24'd0, cfg_q.first};
      ltqc_pkg::RegCommentSecond: prdata = {24'd0, cfg_q.second};
      ltqc_pkg::RegPrefixLength:  prdata = {30'd0, cfg_q.plen};
      default:                    prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  // step only when the queue can absorb two results
  assign step_fire  = in_valid_q && (q_cnt <= ltqc_pkg::ResQCntW'(ltqc_pkg::ResQDepth - 2));
  assign in_ready_o = !in_valid_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (step_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) char_q <= character_i;
  end

  // ---------------- line state ----------------
  ltqc_step u_step (
    .cfg_i      (cfg_q),
    .st_i       (st_q),
    .head0_i    (head0_q),
    .head1_i    (head1_q),
    .char_i     (char_q),
    .st_o       (st_d),
    .head0_we_o (head0_we),
    .head1_we_o (head1_we),
    .res0_o     (res0),
    .res1_o     (res1),
    .res_cnt_o  (res_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (step_fire) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && head0_we) head0_q <= char_q;
    if (step_fire && head1_we) head1_q <= char_q;
  end

  // ---------------- result queue ----------------
  assign push_cnt = step_fire ? res_cnt : 2'd0;
  assign pop      = out_valid_o && out_ready_i;

  ltqc_resq u_resq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (res0),
    .push1_i    (res1),
    .pop_i      (pop),
    .valid_o    (out_valid_o),
    .head_o     (head),
    .cnt_o      (q_cnt)
  );

  assign kind_o         = head.kind;
  assign token_number_o = head.num;
  assign token_start_o  = head.start;
  assign token_length_o = head.len;
  assign last_of_run_o  = head.last;

endmodule

`default_nettype wire

/* rtl/ltqc_step.sv */
// Per-character tokenizer logic: next line state, head byte writes and up
// to two results. Purely combinational; depends on ltqc_pkg.
`default_nettype none

module ltqc_step (
  input  ltqc_pkg::cfg_t                 cfg_i,
  input  ltqc_pkg::st_t                  st_i,
  input  logic [ltqc_pkg::CharW-1:0]     head0_i,
  input  logic [ltqc_pkg::CharW-1:0]     head1_i,
  input  logic [ltqc_pkg::CharW-1:0]     char_i,
  output ltqc_pkg::st_t                  st_o,
  output logic                           head0_we_o,
  output logic                           head1_we_o,
  output ltqc_pkg::res_t                 res0_o,
  output ltqc_pkg::res_t                 res1_o,
  output logic [1:0]                     res_cnt_o
);

  logic                             term;
  logic [ltqc_pkg::CharW-1:0]       cur;
  logic                             adv;
  logic                             tok_emit;
  logic                             le_emit;
  logic                             sep;
  logic                             end_hit;
  logic [ltqc_pkg::LenW-1:0]        len;
  logic [1:0]                       k;
  logic                             is_cmt;
  ltqc_pkg::res_t                   tok_res;
  ltqc_pkg::res_t                   le_res;
  ltqc_pkg::st_t                    st_n;

  assign term = (char_i == ltqc_pkg::CharNul) || (char_i == ltqc_pkg::CharNewline);
  assign cur  = (st_i.esc && !term) ? ltqc_pkg::CharZ : char_i;

  // Effective prefix length; a zero byte cuts the prefix short
  always_comb begin
    k = cfg_i.plen;
    if (k == 2'd0) k = 2'd1;
    if (k == 2'd3) k = 2'd2;
    if (cfg_i.first == ltqc_pkg::CharNul) begin
      k = 2'd0;
    end else if (k == 2'd2 && cfg_i.second == ltqc_pkg::CharNul) begin
      k = 2'd1;
    end
  end

  assign len = (st_i.pos >= ltqc_pkg::PosW'(st_i.start))
             ? st_i.pos - ltqc_pkg::PosW'(st_i.start) : '0;

  assign is_cmt = (len >= ltqc_pkg::LenW'(k))
               && ((k < 2'd1) || (head0_i == cfg_i.first))
               && ((k < 2'd2) || (head1_i == cfg_i.second));

  assign sep     = !st_i.quote && (cur == ltqc_pkg::CharSpace);
  assign end_hit = (sep || cur == ltqc_pkg::CharQuote || term)
                && (st_i.quote || st_i.prev != ltqc_pkg::CharSpace);

  always_comb begin
    st_n     = st_i;
    adv      = 1'b0;
    tok_emit = 1'b0;
    le_emit  = 1'b0;

    if (st_i.limit || st_i.skip) begin
      if (term) begin
        le_emit = 1'b1;
      end else if (st_i.skip) begin
        st_n.skip = 1'b0;
        adv       = 1'b1;
      end
    end else begin
      if (st_i.prev == ltqc_pkg::CharNul) begin
        if (!term && cur != ltqc_pkg::CharSpace) begin
          st_n.start = ltqc_pkg::sat_start(st_i.pos);
        end
      end else if (end_hit) begin
        if (!st_i.cmnt) begin
          if (is_cmt) begin
            st_n.cmnt = 1'b1;
          end else begin
            tok_emit    = 1'b1;
            st_n.tokens = st_i.tokens + 1'b1;
            if (st_n.tokens >= ltqc_pkg::NumW'(ltqc_pkg::MaxTokenCount)) begin
              st_n.limit = 1'b1;
            end
          end
        end
        // closing quote: the following character is dropped
        if (st_i.quote && !term) st_n.skip = 1'b1;
        st_n.quote = 1'b0;
      end else if (!st_i.quote && cur != ltqc_pkg::CharSpace
                   && st_i.prev == ltqc_pkg::CharSpace) begin
        if (cur == ltqc_pkg::CharQuote) begin
          st_n.quote = 1'b1;
          st_n.start = ltqc_pkg::sat_start(st_i.pos + 1'b1);
        end else begin
          st_n.start = ltqc_pkg::sat_start(st_i.pos);
        end
      end
      if (term) begin
        le_emit = 1'b1;
      end else begin
        adv = 1'b1;
      end
    end
  end

  always_comb begin
    tok_res       = '0;
    tok_res.kind  = ltqc_pkg::KindToken;
    tok_res.num   = st_i.tokens;
    tok_res.start = st_i.start;
    tok_res.len   = len;
    tok_res.last  = !term;

    le_res        = '0;
    le_res.kind   = ltqc_pkg::KindLineEnd;
    le_res.num    = st_n.tokens;
    le_res.last   = 1'b1;
  end

  always_comb begin
    st_o       = st_n;
    head0_we_o = 1'b0;
    head1_we_o = 1'b0;
    if (le_emit) begin
      st_o = '0;
    end else if (adv) begin
      head0_we_o = (st_i.pos == ltqc_pkg::PosW'(st_n.start));
      head1_we_o = (st_i.pos == ltqc_pkg::PosW'(st_n.start) + 1'b1);
      st_o.prev  = cur;
      st_o.esc   = (cur == ltqc_pkg::CharBackslash);
      if (st_i.pos < ltqc_pkg::PosW'(ltqc_pkg::LineLength)) begin
        st_o.pos = st_i.pos + 1'b1;
      end
    end
  end

  always_comb begin
    res0_o    = '0;
    res1_o    = '0;
    res_cnt_o = 2'd0;
    if (tok_emit) begin
      res0_o = tok_res;
      if (le_emit) begin
        res1_o    = le_res;
        res_cnt_o = 2'd2;
      end else begin
        res_cnt_o = 2'd1;
      end
    end else if (le_emit) begin
      res0_o    = le_res;
      res_cnt_o = 2'd1;
    end
  end

endmodule

`default_nettype wire

/* rtl/ltqc_resq.sv */
// Small result queue: takes up to two results a cycle, hands out one.
// Its head entry is the registered output; depends on ltqc_pkg.
`default_nettype none

module ltqc_resq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        push_cnt_i,
  input  ltqc_pkg::res_t                    push0_i,
  input  ltqc_pkg::res_t                    push1_i,
  input  logic                              pop_i,
  output logic                              valid_o,
  output ltqc_pkg::res_t                    head_o,
  output logic [ltqc_pkg::ResQCntW-1:0]     cnt_o
);

  ltqc_pkg::res_t                    mem_q [ltqc_pkg::ResQDepth];
  logic [ltqc_pkg::ResQPtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [ltqc_pkg::ResQCntW-1:0]     cnt_q, cnt_d;
  logic [ltqc_pkg::ResQPtrW-1:0]     wr1;

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign cnt_o   = cnt_q;
  assign wr1     = wr_q + 1'b1;

  assign wr_d  = wr_q + ltqc_pkg::ResQPtrW'(push_cnt_i);
  assign rd_d  = rd_q + ltqc_pkg::ResQPtrW'(pop_i);
  assign cnt_d = cnt_q + ltqc_pkg::ResQCntW'(push_cnt_i) - ltqc_pkg::ResQCntW'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_q] <= push0_i;
    if (push_cnt_i == 2'd2) mem_q[wr1]  <= push1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/ltqc_checker.sv */
// Port-level checks for line_tokenizer_quotes_comments, bound to the top.
// Depends on ltqc_pkg.
`default_nettype none

module ltqc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [ltqc_pkg::CharW-1:0]      character_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            kind_o,
  input logic [ltqc_pkg::NumW-1:0]       token_number_o,
  input logic [ltqc_pkg::StartW-1:0]     token_start_o,
  input logic [ltqc_pkg::LenW-1:0]       token_length_o,
  input logic                            last_of_run_o
);

  // an offered character holds until its transfer
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(character_i))
    else $error("input changed while stalled");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o)
      && $stable(token_number_o) && $stable(token_start_o)
      && $stable(token_length_o) && $stable(last_of_run_o))
    else $error("result changed while stalled");

  // line end closes the run and carries no position
  a_line_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == ltqc_pkg::KindLineEnd |->
      last_of_run_o && token_start_o == '0 && token_length_o == '0)
    else $error("malformed line end result");

  // a token not last of its run is followed at once by the line end
  a_token_then_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && kind_o == ltqc_pkg::KindToken && !last_of_run_o
      |=> out_valid_o && kind_o == ltqc_pkg::KindLineEnd)
    else $error("line end missing after token");

  // counts reach the limit, token indexes stay below it
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_number_o <= ltqc_pkg::NumW'(ltqc_pkg::MaxTokenCount)
      && (kind_o == ltqc_pkg::KindLineEnd
          || token_number_o < ltqc_pkg::NumW'(ltqc_pkg::MaxTokenCount)))
    else $error("token number beyond limit");

endmodule

bind line_tokenizer_quotes_comments ltqc_checker u_ltqc_checker (.*);

`default_nettype wire
